### rtl/lasf_pkg.sv
// Package for the lamp/app sync state machine: payload structs, register
// indexes, reset values, dim step codes, IR pulse counts and LED colours. No dependencies.
`default_nettype none

package lasf_pkg;

    typedef struct packed {
        logic       app_on;
        logic       lamp_on;
        logic       button_pressed;
        logic [9:0] duty_tenths;
    } in_t;

    typedef struct packed {
        logic [2:0]  fsm_state;
        logic        led_write;
        logic [2:0]  led_rgb;
        logic        ir_power_toggle;
        logic [1:0]  ir_up_pulses;
        logic [1:0]  ir_down_pulses;
        logic        lamp_toggle;
        logic        app_toggle;
        logic [15:0] wait_ms;
    } out_t;

    typedef struct packed {
        logic [3:0]  retry_limit;
        logic [9:0]  dim_threshold_low;
        logic [9:0]  dim_threshold_high;
        logic [15:0] lamp_wait_ms;
        logic [15:0] app_wait_ms;
        logic [15:0] poll_wait_ms;
        logic [15:0] boot_wait_ms;
    } cfg_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_RETRY_LIMIT  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIM_THR_LOW  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIM_THR_HIGH = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LAMP_WAIT    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_APP_WAIT     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_POLL_WAIT    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_BOOT_WAIT    = 3'd6;

    localparam cfg_t CFG_RESET = '{
        retry_limit:        4'd2,
        dim_threshold_low:  10'd250,
        dim_threshold_high: 10'd980,
        lamp_wait_ms:       16'd1000,
        app_wait_ms:        16'd1000,
        poll_wait_ms:       16'd50,
        boot_wait_ms:       16'd1000
    };

    localparam logic [1:0] DIM_STEP_ONE   = 2'd0;
    localparam logic [1:0] DIM_STEP_TWO   = 2'd1;
    localparam logic [1:0] DIM_STEP_THREE = 2'd2;

    localparam logic [1:0] UP_PULSES     = 2'd3;
    localparam logic [1:0] DOWN_STEP_ONE = 2'd2;
    localparam logic [1:0] DOWN_STEP_TWO = 2'd1;

    localparam logic [2:0] RGB_WHITE = 3'd7;
    localparam logic [2:0] RGB_GREEN = 3'd2;
    localparam logic [2:0] RGB_RED   = 3'd4;
    localparam logic [2:0] RGB_BLUE  = 3'd1;

endpackage

`default_nettype wire

### rtl/lasf_cfg.sv
// Configuration register file for the lamp/app sync state machine.
// Depends on lasf_pkg for the register struct, indexes and reset values.
`default_nettype none

module lasf_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write_en,
    input  wire logic [lasf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [lasf_pkg::CFG_DATA_W-1:0]  cfg_data,
    output lasf_pkg::cfg_t                      cfg
);

    lasf_pkg::cfg_t cfg_reg;
    lasf_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                lasf_pkg::CFG_RETRY_LIMIT:  cfg_next.retry_limit        = cfg_data[3:0];
                lasf_pkg::CFG_DIM_THR_LOW:  cfg_next.dim_threshold_low  = cfg_data[9:0];
                lasf_pkg::CFG_DIM_THR_HIGH: cfg_next.dim_threshold_high = cfg_data[9:0];
                lasf_pkg::CFG_LAMP_WAIT:    cfg_next.lamp_wait_ms       = cfg_data;
                lasf_pkg::CFG_APP_WAIT:     cfg_next.app_wait_ms        = cfg_data;
                lasf_pkg::CFG_POLL_WAIT:    cfg_next.poll_wait_ms       = cfg_data;
                lasf_pkg::CFG_BOOT_WAIT:    cfg_next.boot_wait_ms       = cfg_data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= lasf_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### rtl/lasf_dim.sv
// Dim step classifier and IR brightness pulse selection.
// Depends on lasf_pkg for the step codes and pulse counts.
`default_nettype none

module lasf_dim (
    input  wire logic [9:0] duty_tenths,
    input  wire logic [9:0] thr_low,
    input  wire logic [9:0] thr_high,
    input  wire logic [1:0] step_now,
    input  wire logic [1:0] step_sent,
    output logic      [1:0] step_new,
    output logic      [1:0] up_pulses,
    output logic      [1:0] down_pulses
);

    always_comb
    begin
        if (duty_tenths < thr_low)
        begin
            step_new = lasf_pkg::DIM_STEP_ONE;
        end
        else if (duty_tenths < thr_high)
        begin
            step_new = lasf_pkg::DIM_STEP_TWO;
        end
        else
        begin
            step_new = lasf_pkg::DIM_STEP_THREE;
        end
    end

    always_comb
    begin
        up_pulses   = 2'd0;
        down_pulses = 2'd0;
        if (step_now != step_sent)
        begin
            case (step_now)
                lasf_pkg::DIM_STEP_ONE:
                begin
                    up_pulses   = lasf_pkg::UP_PULSES;
                    down_pulses = lasf_pkg::DOWN_STEP_ONE;
                end
                lasf_pkg::DIM_STEP_TWO:
                begin
                    up_pulses   = lasf_pkg::UP_PULSES;
                    down_pulses = lasf_pkg::DOWN_STEP_TWO;
                end
                lasf_pkg::DIM_STEP_THREE:
                begin
                    up_pulses   = lasf_pkg::UP_PULSES;
                end
                default:
                begin
                    up_pulses   = 2'd0;
                    down_pulses = 2'd0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/lamp_app_sync_fsm.sv
// Top level of the lamp/app sync state machine: state, step logic and
// result register. Depends on lasf_pkg, lasf_cfg and lasf_dim.
//
// Usage:
//   Each input transaction on in_valid/in_ready is one tick carrying the
//   observed app and lamp states, a button press and the duty cycle. Each
//   tick yields exactly one result transaction on out_valid/out_ready with
//   the state after the tick, LED update, IR and toggle strobes and wait.
//   The result is registered: it is valid in the cycle after the input transaction.
//   Throughput: one transaction per cycle while out_ready is high; the state update
//   and the result are computed in a single pass from the state registers and the input.
//   A stalled receiver holds the result register; in_ready stays high while
//   the result register is empty or being taken in the same cycle, so ticks
//   keep flowing with no bubble as long as out_ready is high.
//   Configuration: cfg_write_en, cfg_index and cfg_data write one register
//   per cycle; writes to unused indexes are dropped.
//   Reset: rst_n clears the result valid flag and returns the machine to the
//   initialisation state with its entry action pending and the registers
//   to their defaults.
`default_nettype none

module lamp_app_sync_fsm (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire lasf_pkg::in_t                    in_data,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output lasf_pkg::out_t                        out_data,
    input  wire logic                             cfg_write_en,
    input  wire logic [lasf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [lasf_pkg::CFG_DATA_W-1:0]  cfg_data
);

    typedef enum logic [2:0] {
        ST_INIT          = 3'd0,
        ST_LAMP_ON       = 3'd1,
        ST_LAMP_OFF      = 3'd2,
        ST_TURN_LAMP_OFF = 3'd3,
        ST_TURN_APP_OFF  = 3'd4,
        ST_TURN_LAMP_ON  = 3'd5,
        ST_TURN_APP_ON   = 3'd6
    } state_t;

    lasf_pkg::cfg_t cfg;

    state_t          state_reg, state_next;
    logic            entry_reg, entry_next;
    logic [3:0]      retry_reg, retry_next;
    logic [1:0]      step_now_reg, step_now_next;
    logic [1:0]      step_sent_reg, step_sent_next;
    logic            out_valid_reg;
    lasf_pkg::out_t  out_data_reg;
    lasf_pkg::out_t  res;

    logic            accept;
    logic            want_on;
    logic [1:0]      sent_eff;
    logic [1:0]      step_new;
    logic [1:0]      up_pulses;
    logic [1:0]      down_pulses;
    logic [3:0]      retry_base;
    logic [3:0]      retry_cnt;

    lasf_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    assign sent_eff = entry_reg ? step_now_reg : step_sent_reg;

    lasf_dim u_dim (
        .duty_tenths (in_data.duty_tenths),
        .thr_low     (cfg.dim_threshold_low),
        .thr_high    (cfg.dim_threshold_high),
        .step_now    (step_now_reg),
        .step_sent   (sent_eff),
        .step_new    (step_new),
        .up_pulses   (up_pulses),
        .down_pulses (down_pulses)
    );

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        entry_next     = 1'b0;
        retry_next     = retry_reg;
        step_now_next  = step_now_reg;
        step_sent_next = step_sent_reg;
        res            = '0;
        want_on        = (state_reg == ST_TURN_LAMP_ON) || (state_reg == ST_TURN_APP_ON);
        retry_base     = (entry_reg && want_on) ? 4'd0 : retry_reg;
        retry_cnt      = in_data.lamp_on == want_on ? 4'd0 : retry_base + 4'd1;

        case (state_reg)
            ST_INIT:
            begin
                if (entry_reg)
                begin
                    res.led_write = 1'b1;
                    res.led_rgb   = lasf_pkg::RGB_WHITE;
                    res.wait_ms   = cfg.boot_wait_ms;
                end
                if (in_data.app_on && in_data.lamp_on)
                    state_next = ST_LAMP_ON;
                else if (!in_data.app_on && !in_data.lamp_on)
                    state_next = ST_LAMP_OFF;
                else if (in_data.lamp_on)
                    state_next = ST_TURN_APP_ON;
                else
                    state_next = ST_TURN_APP_OFF;
            end
            ST_LAMP_ON:
            begin
                if (entry_reg)
                begin
                    res.led_write = 1'b1;
                    res.led_rgb   = lasf_pkg::RGB_GREEN;
                end
                res.ir_power_toggle = in_data.button_pressed;
                res.ir_up_pulses    = up_pulses;
                res.ir_down_pulses  = down_pulses;
                res.wait_ms         = cfg.poll_wait_ms;
                step_sent_next      = step_now_reg;
                step_now_next       = step_new;
                if (!in_data.lamp_on)
                    state_next = ST_TURN_APP_OFF;
                else if (!in_data.app_on)
                    state_next = ST_TURN_LAMP_OFF;
            end
            ST_LAMP_OFF:
            begin
                if (entry_reg)
                begin
                    res.led_write = 1'b1;
                    res.led_rgb   = lasf_pkg::RGB_RED;
                end
                res.ir_power_toggle = in_data.button_pressed;
                if (in_data.lamp_on)
                    state_next = ST_TURN_APP_ON;
                else if (in_data.app_on)
                    state_next = ST_TURN_LAMP_ON;
            end
            ST_TURN_LAMP_OFF, ST_TURN_LAMP_ON:
            begin
                if (entry_reg)
                begin
                    res.led_write = 1'b1;
                    res.led_rgb   = lasf_pkg::RGB_BLUE;
                end
                res.lamp_toggle = 1'b1;
                res.wait_ms     = cfg.lamp_wait_ms;
                if (retry_cnt >= cfg.retry_limit)
                begin
                    retry_next = 4'd0;
                    state_next = want_on ? ST_TURN_APP_OFF : ST_TURN_APP_ON;
                end
                else
                begin
                    retry_next = retry_cnt;
                    if (in_data.lamp_on == want_on)
                        state_next = want_on ? ST_LAMP_ON : ST_LAMP_OFF;
                end
            end
            ST_TURN_APP_OFF, ST_TURN_APP_ON:
            begin
                if (entry_reg)
                begin
                    res.led_write = 1'b1;
                    res.led_rgb   = lasf_pkg::RGB_BLUE;
                end
                res.app_toggle = 1'b1;
                res.wait_ms    = cfg.app_wait_ms;
                if (in_data.app_on == want_on)
                    state_next = want_on ? ST_LAMP_ON : ST_LAMP_OFF;
            end
            default:
            begin
                state_next = ST_INIT;
                entry_next = 1'b1;
            end
        endcase

        if (state_next != state_reg)
            entry_next = 1'b1;
        res.fsm_state = state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            entry_reg     <= 1'b1;
            retry_reg     <= 4'd0;
            step_now_reg  <= lasf_pkg::DIM_STEP_ONE;
            step_sent_reg <= lasf_pkg::DIM_STEP_ONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg     <= state_next;
                entry_reg     <= entry_next;
                retry_reg     <= retry_next;
                step_now_reg  <= step_now_next;
                step_sent_reg <= step_sent_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while result stalled");

    a_lamp_off_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
        accept && state_reg == ST_LAMP_OFF |=> out_data.wait_ms == 16'd0)
        else $error("nonzero wait from lamp off state");

    a_single_toggle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.lamp_toggle && out_data.app_toggle))
        else $error("lamp and app toggled in one transaction");

    a_led_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.led_write |-> out_data.led_rgb == 3'd0)
        else $error("led colour without led write");

endmodule

`default_nettype wire

### bench/tb_lamp_app_sync_fsm.sv
// Testbench for lamp_app_sync_fsm: directed and random ticks under several register
// settings, random idling on both channels and a long receiver hold-off, each result
// checked against a predictor in this file. Depends on lasf_pkg and the RTL.
`timescale 1ns / 100ps

module tb_lamp_app_sync_fsm;

    localparam logic [2:0] ST_INIT          = 3'd0;
    localparam logic [2:0] ST_LAMP_ON       = 3'd1;
    localparam logic [2:0] ST_LAMP_OFF      = 3'd2;
    localparam logic [2:0] ST_TURN_LAMP_OFF = 3'd3;
    localparam logic [2:0] ST_TURN_APP_OFF  = 3'd4;
    localparam logic [2:0] ST_TURN_LAMP_ON  = 3'd5;
    localparam logic [2:0] ST_TURN_APP_ON   = 3'd6;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int PHASE_TICKS     = 100;

    localparam int CFG_INDEX_W = lasf_pkg::CFG_INDEX_W;
    localparam int CFG_DATA_W  = lasf_pkg::CFG_DATA_W;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   in_valid     = 1'b0;
    logic                   in_ready;
    lasf_pkg::in_t          in_data      = '0;
    logic                   out_valid;
    logic                   out_ready    = 1'b0;
    lasf_pkg::out_t         out_data;
    logic                   cfg_write_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;

    lasf_pkg::cfg_t sync_cfg      = lasf_pkg::CFG_RESET;
    logic [2:0]     sync_state    = ST_INIT;
    logic           entry_due     = 1'b1;
    logic [3:0]     retry_tally   = 4'd0;
    logic [1:0]     dim_step_cur  = lasf_pkg::DIM_STEP_ONE;
    logic [1:0]     dim_step_done = lasf_pkg::DIM_STEP_ONE;

    lasf_pkg::out_t expected_results[$];
    int   mismatches   = 0;
    int   quiet_cycles = 0;
    logic idle_on      = 1'b1;
    int   hold_token   = 0;
    int   hold_seen    = 0;
    int   stall_left   = 0;
    logic scene_app    = 1'b1;
    logic scene_lamp   = 1'b1;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    lamp_app_sync_fsm u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    function automatic lasf_pkg::out_t sync_tick(input lasf_pkg::in_t t);
        lasf_pkg::out_t r;
        logic           entering;
        logic           want_on;
        logic [2:0]     nxt;
        r        = '0;
        entering = entry_due;
        entry_due = 1'b0;
        nxt      = sync_state;
        want_on  = 1'b0;
        case (sync_state)
            ST_INIT:
            begin
                if (entering)
                begin
                    r.led_write = 1'b1;
                    r.led_rgb   = lasf_pkg::RGB_WHITE;
                    r.wait_ms   = sync_cfg.boot_wait_ms;
                end
                if (t.app_on && t.lamp_on)
                    nxt = ST_LAMP_ON;
                else if (!t.app_on && !t.lamp_on)
                    nxt = ST_LAMP_OFF;
                else if (t.lamp_on)
                    nxt = ST_TURN_APP_ON;
                else
                    nxt = ST_TURN_APP_OFF;
            end
            ST_LAMP_ON:
            begin
                if (entering)
                begin
                    r.led_write   = 1'b1;
                    r.led_rgb     = lasf_pkg::RGB_GREEN;
                    dim_step_done = dim_step_cur;
                end
                r.ir_power_toggle = t.button_pressed;
                if (dim_step_cur != dim_step_done)
                begin
                    case (dim_step_cur)
                        lasf_pkg::DIM_STEP_ONE:
                        begin
                            r.ir_up_pulses   = lasf_pkg::UP_PULSES;
                            r.ir_down_pulses = lasf_pkg::DOWN_STEP_ONE;
                        end
                        lasf_pkg::DIM_STEP_TWO:
                        begin
                            r.ir_up_pulses   = lasf_pkg::UP_PULSES;
                            r.ir_down_pulses = lasf_pkg::DOWN_STEP_TWO;
                        end
                        lasf_pkg::DIM_STEP_THREE:
                            r.ir_up_pulses = lasf_pkg::UP_PULSES;
                        default:
                            r.ir_up_pulses = 2'd0;
                    endcase
                    dim_step_done = dim_step_cur;
                end
                if (t.duty_tenths < sync_cfg.dim_threshold_low)
                    dim_step_cur = lasf_pkg::DIM_STEP_ONE;
                else if (t.duty_tenths < sync_cfg.dim_threshold_high)
                    dim_step_cur = lasf_pkg::DIM_STEP_TWO;
                else
                    dim_step_cur = lasf_pkg::DIM_STEP_THREE;
                r.wait_ms = sync_cfg.poll_wait_ms;
                if (!t.app_on)
                    nxt = ST_TURN_LAMP_OFF;
                if (!t.lamp_on)
                    nxt = ST_TURN_APP_OFF;
            end
            ST_LAMP_OFF:
            begin
                if (entering)
                begin
                    r.led_write = 1'b1;
                    r.led_rgb   = lasf_pkg::RGB_RED;
                end
                r.ir_power_toggle = t.button_pressed;
                if (t.app_on)
                    nxt = ST_TURN_LAMP_ON;
                if (t.lamp_on)
                    nxt = ST_TURN_APP_ON;
            end
            ST_TURN_LAMP_OFF, ST_TURN_LAMP_ON:
            begin
                want_on = (sync_state == ST_TURN_LAMP_ON);
                if (entering)
                begin
                    r.led_write = 1'b1;
                    r.led_rgb   = lasf_pkg::RGB_BLUE;
                    if (want_on)
                        retry_tally = 4'd0;
                end
                r.lamp_toggle = 1'b1;
                retry_tally   = retry_tally + 4'd1;
                r.wait_ms     = sync_cfg.lamp_wait_ms;
                if (t.lamp_on == want_on)
                begin
                    retry_tally = 4'd0;
                    nxt = want_on ? ST_LAMP_ON : ST_LAMP_OFF;
                end
                if (retry_tally >= sync_cfg.retry_limit)
                begin
                    retry_tally = 4'd0;
                    nxt = want_on ? ST_TURN_APP_OFF : ST_TURN_APP_ON;
                end
            end
            ST_TURN_APP_OFF, ST_TURN_APP_ON:
            begin
                want_on = (sync_state == ST_TURN_APP_ON);
                if (entering)
                begin
                    r.led_write = 1'b1;
                    r.led_rgb   = lasf_pkg::RGB_BLUE;
                end
                r.app_toggle = 1'b1;
                r.wait_ms    = sync_cfg.app_wait_ms;
                if (t.app_on == want_on)
                    nxt = want_on ? ST_LAMP_ON : ST_LAMP_OFF;
            end
            default:
                nxt = ST_INIT;
        endcase
        if (nxt != sync_state || sync_state > ST_TURN_APP_ON)
            entry_due = 1'b1;
        sync_state  = nxt;
        r.fsm_state = sync_state;
        return r;
    endfunction

    function automatic lasf_pkg::in_t make_tick(input logic a, input logic l, input logic b,
                                                input logic [9:0] d);
        lasf_pkg::in_t t;
        t.app_on         = a;
        t.lamp_on        = l;
        t.button_pressed = b;
        t.duty_tenths    = d;
        return t;
    endfunction

    // Mostly a steady scene with occasional flips, so the correcting states settle or retry.
    function automatic lasf_pkg::in_t random_tick();
        lasf_pkg::in_t t;
        int            duty;
        if ($urandom_range(0, 99) < 7)
            scene_app = !scene_app;
        if ($urandom_range(0, 99) < 7)
            scene_lamp = !scene_lamp;
        t.app_on  = scene_app;
        t.lamp_on = scene_lamp;
        if ($urandom_range(0, 19) == 0)
        begin
            t.app_on  = 1'($urandom_range(0, 1));
            t.lamp_on = 1'($urandom_range(0, 1));
        end
        t.button_pressed = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 5))
            0, 1: duty = $urandom_range(0, 1023);
            2: duty = int'(sync_cfg.dim_threshold_low) + int'($urandom_range(0, 4)) - 2;
            3: duty = int'(sync_cfg.dim_threshold_high) + int'($urandom_range(0, 4)) - 2;
            4: duty = ($urandom_range(0, 1) == 1) ? 1000 : 1023;
            default: duty = $urandom_range(0, 1000);
        endcase
        if (duty < 0)
            duty = 0;
        else if (duty > 1023)
            duty = 1023;
        t.duty_tenths = duty[9:0];
        return t;
    endfunction

    function automatic int gap_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic send_tick(input lasf_pkg::in_t t);
        int gap;
        gap = idle_on ? gap_cycles() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= t;
        do
            @(posedge clk);
        while (!in_ready);
        expected_results.push_back(sync_tick(t));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        @(posedge clk);
    endtask

    task automatic load_settings(input lasf_pkg::cfg_t c);
        sync_cfg = c;
        write_reg(lasf_pkg::CFG_RETRY_LIMIT, CFG_DATA_W'(c.retry_limit));
        write_reg(lasf_pkg::CFG_DIM_THR_LOW, CFG_DATA_W'(c.dim_threshold_low));
        write_reg(lasf_pkg::CFG_DIM_THR_HIGH, CFG_DATA_W'(c.dim_threshold_high));
        write_reg(lasf_pkg::CFG_LAMP_WAIT, c.lamp_wait_ms);
        write_reg(lasf_pkg::CFG_APP_WAIT, c.app_wait_ms);
        write_reg(lasf_pkg::CFG_POLL_WAIT, c.poll_wait_ms);
        write_reg(lasf_pkg::CFG_BOOT_WAIT, c.boot_wait_ms);
        cfg_write_en <= 1'b0;
    endtask

    task automatic run_phase(input lasf_pkg::cfg_t c, input int count);
        load_settings(c);
        repeat (count) send_tick(random_tick());
        drain_results();
    endtask

    task automatic test_directed_sequence();
        send_tick(make_tick(1'b1, 1'b1, 1'b0, 10'd0));
        send_tick(make_tick(1'b1, 1'b1, 1'b1, 10'd0));
        send_tick(make_tick(1'b1, 1'b1, 1'b0, 10'd500));
        send_tick(make_tick(1'b1, 1'b1, 1'b1, 10'd1000));
        send_tick(make_tick(1'b1, 1'b1, 1'b0, 10'd1023));
        send_tick(make_tick(1'b1, 1'b1, 1'b0, 10'd0));
        send_tick(make_tick(1'b1, 1'b1, 1'b0, 10'd0));
        send_tick(make_tick(1'b0, 1'b0, 1'b0, 10'd250));
        send_tick(make_tick(1'b1, 1'b0, 1'b0, 10'd979));
        send_tick(make_tick(1'b0, 1'b0, 1'b0, 10'd980));
        send_tick(make_tick(1'b1, 1'b1, 1'b1, 10'd249));
        send_tick(make_tick(1'b1, 1'b1, 1'b0, 10'd682));
        send_tick(make_tick(1'b0, 1'b1, 1'b0, 10'd341));
        send_tick(make_tick(1'b0, 1'b1, 1'b0, 10'd0));
        send_tick(make_tick(1'b0, 1'b1, 1'b0, 10'd0));
        send_tick(make_tick(1'b0, 1'b1, 1'b0, 10'd0));
        send_tick(make_tick(1'b1, 1'b1, 1'b0, 10'd1000));
        send_tick(make_tick(1'b1, 1'b0, 1'b1, 10'd500));
        send_tick(make_tick(1'b0, 1'b0, 1'b0, 10'd0));
        send_tick(make_tick(1'b1, 1'b0, 1'b0, 10'd0));
        send_tick(make_tick(1'b0, 1'b1, 1'b0, 10'd0));
        send_tick(make_tick(1'b1, 1'b1, 1'b0, 10'd250));
        drain_results();
    endtask

    task automatic test_random_defaults();
        run_phase(lasf_pkg::CFG_RESET, PHASE_TICKS);
    endtask

    task automatic test_register_extremes();
        lasf_pkg::cfg_t c;
        c = '{retry_limit: 4'd0, dim_threshold_low: 10'd0, dim_threshold_high: 10'd1023,
              lamp_wait_ms: 16'd0, app_wait_ms: 16'd0, poll_wait_ms: 16'd0,
              boot_wait_ms: 16'd0};
        run_phase(c, PHASE_TICKS);
        c = '{retry_limit: 4'd15, dim_threshold_low: 10'd1000, dim_threshold_high: 10'd0,
              lamp_wait_ms: 16'hFFFF, app_wait_ms: 16'hFFFF, poll_wait_ms: 16'hFFFF,
              boot_wait_ms: 16'hFFFF};
        run_phase(c, PHASE_TICKS);
    endtask

    task automatic test_random_settings();
        lasf_pkg::cfg_t c;
        for (int k = 0; k < 3; k++)
        begin
            c.retry_limit        = (k == 0) ? 4'd1 : 4'($urandom_range(1, 15));
            c.dim_threshold_low  = 10'($urandom_range(0, 1000));
            c.dim_threshold_high = 10'($urandom_range(0, 1000));
            c.lamp_wait_ms       = 16'($urandom_range(0, 65535));
            c.app_wait_ms        = 16'($urandom_range(0, 65535));
            c.poll_wait_ms       = 16'($urandom_range(0, 65535));
            c.boot_wait_ms       = 16'($urandom_range(0, 65535));
            idle_on <= (k != 2);
            run_phase(c, PHASE_TICKS);
        end
    endtask

    task automatic test_output_backpressure();
        idle_on    <= 1'b0;
        hold_token <= hold_token + 1;
        repeat (40) send_tick(random_tick());
        drain_results();
        idle_on <= 1'b1;
    endtask

    task automatic check_field(input string name, input longint unsigned e,
                               input longint unsigned a);
        if (e !== a)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, e, a);
        end
    endtask

    always @(posedge clk)
    begin : check_results
        lasf_pkg::out_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with no pending tick: %h", $realtime, out_data);
            end
            else
            begin
                exp_r = expected_results.pop_front();
                check_field("fsm_state", 64'(exp_r.fsm_state), 64'(out_data.fsm_state));
                check_field("led_write", 64'(exp_r.led_write), 64'(out_data.led_write));
                check_field("led_rgb", 64'(exp_r.led_rgb), 64'(out_data.led_rgb));
                check_field("ir_power_toggle", 64'(exp_r.ir_power_toggle),
                            64'(out_data.ir_power_toggle));
                check_field("ir_up_pulses", 64'(exp_r.ir_up_pulses),
                            64'(out_data.ir_up_pulses));
                check_field("ir_down_pulses", 64'(exp_r.ir_down_pulses),
                            64'(out_data.ir_down_pulses));
                check_field("lamp_toggle", 64'(exp_r.lamp_toggle), 64'(out_data.lamp_toggle));
                check_field("app_toggle", 64'(exp_r.app_toggle), 64'(out_data.app_toggle));
                check_field("wait_ms", 64'(exp_r.wait_ms), 64'(out_data.wait_ms));
            end
        end
    end

    // Hold off the receiver: a requested long stretch first, else random short and long stalls while idling is on.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_token != hold_seen)
        begin
            hold_seen  <= hold_token;
            stall_left <= HOLD_OFF_CYCLES;
            out_ready  <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 99) < 12)
        begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                      : $urandom_range(0, 2);
            out_ready  <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write_en)
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_lamp_app_sync_fsm: errors");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_sequence();
        test_random_defaults();
        test_register_extremes();
        test_random_settings();
        test_output_backpressure();
        repeat (5) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb_lamp_app_sync_fsm: clean");
        else
            $display("tb_lamp_app_sync_fsm: errors");
        $finish;
    end

endmodule

### files.f
rtl/lasf_pkg.sv
rtl/lasf_cfg.sv
rtl/lasf_dim.sv
rtl/lamp_app_sync_fsm.sv
bench/tb_lamp_app_sync_fsm.sv
